// ----- rtl/core/assert_macros.svh -----
// assertion macros included by the golden_section_minimizer rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// condition holds in the following cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/core/gsm_pkg.sv -----
// types and constants of the golden section minimizer
// no dependencies
`default_nettype none

package gsm_pkg;

  localparam logic [31:0] RATIO_Q32 = 32'd1640531527;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_VALUE = 1'b1;

  localparam logic [1:0] KIND_EVAL    = 2'd0;
  localparam logic [1:0] KIND_DONE    = 2'd1;
  localparam logic [1:0] KIND_IGNORED = 2'd2;

  localparam logic [1:0] CFG_LOWER = 2'd0;
  localparam logic [1:0] CFG_UPPER = 2'd1;
  localparam logic [1:0] CFG_TOL   = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_FIRST_LOW,
    PH_FIRST_HIGH,
    PH_LOW,
    PH_HIGH
  } phase_t;

  typedef struct packed {
    logic               req_type;
    logic signed [31:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic signed [31:0] point;
  } out_item_t;

endpackage

`default_nettype wire

// ----- rtl/core/gsm_step.sv -----
// golden ratio step: round(width * 0.381966) as a constant multiply
// depends on gsm_pkg
`default_nettype none

module gsm_step (
  input  logic [31:0] width,
  output logic [31:0] step
);
  import gsm_pkg::*;

  logic [63:0] prod;

  assign prod = ({32'd0, width} * {32'd0, RATIO_Q32}) + 64'h0000_0000_8000_0000;
  assign step = prod[63:32];

endmodule

`default_nettype wire

// ----- rtl/core/golden_section_minimizer.sv -----
// golden section minimizer over a configured interval, signed Q8.24 values
// depends on gsm_pkg, gsm_step and assert_macros.svh
//
// usage: in_item carries a start (req_type 0) or the objective value at the
// last requested point (req_type 1). every item yields exactly one out_item:
// kind 0 asks for f at point, kind 1 gives the minimum estimate (midpoint of
// the final interval), kind 2 means a value arrived while no search ran.
// an item is taken at a clock edge with valid high and stall low.
// an accepted item goes from the input register through one pass of subtract,
// 32x32 constant multiply, add and compares into the result register. one
// item per cycle is sustained while out_stall is low; the external objective
// evaluator sets the real pace of a search.
// when out_stall is high the result register holds its item and the input
// register fills, after which in_stall rises; nothing is dropped.
// the cfg port writes lower_bound, upper_bound, tolerance (index 0..2);
// write only while no search item is in flight. a start uses the values then.
// reset (rst, synchronous) loads the default bounds and tolerance, empties
// both registers and leaves the search idle.
`default_nettype none

module golden_section_minimizer #(
  parameter int FRAC_BITS = 24
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  gsm_pkg::in_item_t in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output gsm_pkg::out_item_t out_item,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  import gsm_pkg::*;

  `include "assert_macros.svh"

  localparam logic [63:0] ONE_FX    = 64'd1 << FRAC_BITS;
  localparam logic [31:0] LOWER_RST = 32'(64'd3 << FRAC_BITS);
  localparam logic [31:0] UPPER_RST = 32'(64'd5 << FRAC_BITS);
  localparam logic [30:0] TOL_RST   = 31'((ONE_FX + 64'd50000) / 64'd100000);

  logic signed [31:0] lower_bound, upper_bound;
  logic [30:0]        tolerance;

  logic     in_q_valid;
  in_item_t in_q;
  logic     proceed, proc;

  phase_t             phase, phase_next;
  logic signed [31:0] left_end, right_end, inner_low, inner_high;
  logic signed [31:0] value_low, value_high;
  logic signed [31:0] left_end_next, right_end_next, inner_low_next, inner_high_next;
  logic signed [31:0] value_low_next, value_high_next;
  out_item_t          result;

  logic               swap;
  logic signed [31:0] lo_s, hi_s, vl_eff, vh_eff;
  logic [31:0]        start_w, cur_w, shrink_w, mul_w, step;
  logic               keep_low, finish;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      lower_bound <= LOWER_RST;
      upper_bound <= UPPER_RST;
      tolerance   <= TOL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LOWER: lower_bound <= cfg_data;
        CFG_UPPER: upper_bound <= cfg_data;
        CFG_TOL:   tolerance   <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  assign proceed  = !out_valid || !out_stall;
  assign proc     = in_q_valid && proceed;
  assign in_stall = in_q_valid && !proceed;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_q <= in_item;
    end
  end

  // datapath
  assign swap    = lower_bound > upper_bound;
  assign lo_s    = swap ? upper_bound : lower_bound;
  assign hi_s    = swap ? lower_bound : upper_bound;
  assign start_w = 32'(hi_s - lo_s);
  assign cur_w   = 32'(right_end - left_end);

  assign vl_eff   = (phase == PH_LOW) ? in_q.sample_value : value_low;
  assign vh_eff   = (phase == PH_FIRST_HIGH || phase == PH_HIGH) ? in_q.sample_value
                                                                  : value_high;
  assign keep_low = vl_eff <= vh_eff;
  assign finish   = (cur_w <= {1'b0, tolerance}) || (cur_w <= 32'd1);
  assign shrink_w = keep_low ? 32'(inner_high - left_end) : 32'(right_end - inner_low);
  assign mul_w    = (in_q.req_type == REQ_START) ? start_w : shrink_w;

  gsm_step u_step (
    .width (mul_w),
    .step  (step)
  );

  always_comb begin
    phase_next      = phase;
    left_end_next   = left_end;
    right_end_next  = right_end;
    inner_low_next  = inner_low;
    inner_high_next = inner_high;
    value_low_next  = value_low;
    value_high_next = value_high;
    result.result_kind = KIND_EVAL;
    result.point       = 32'sd0;
    if (in_q.req_type == REQ_START) begin
      left_end_next   = lo_s;
      right_end_next  = hi_s;
      inner_low_next  = lo_s + $signed(step);
      inner_high_next = hi_s - $signed(step);
      value_low_next  = 32'sd0;
      value_high_next = 32'sd0;
      phase_next      = PH_FIRST_LOW;
      result.point    = lo_s + $signed(step);
    end else begin
      case (phase)
        PH_FIRST_LOW: begin
          value_low_next = in_q.sample_value;
          phase_next     = PH_FIRST_HIGH;
          result.point   = inner_high;
        end
        PH_FIRST_HIGH, PH_HIGH, PH_LOW: begin
          value_low_next  = vl_eff;
          value_high_next = vh_eff;
          if (finish) begin
            phase_next         = PH_IDLE;
            result.result_kind = KIND_DONE;
            result.point       = left_end + $signed({1'b0, cur_w[31:1]});
          end else if (keep_low) begin
            right_end_next  = inner_high;
            inner_high_next = inner_low;
            value_high_next = vl_eff;
            inner_low_next  = left_end + $signed(step);
            phase_next      = PH_LOW;
            result.point    = left_end + $signed(step);
          end else begin
            left_end_next   = inner_low;
            inner_low_next  = inner_high;
            value_low_next  = vh_eff;
            inner_high_next = right_end - $signed(step);
            phase_next      = PH_HIGH;
            result.point    = right_end - $signed(step);
          end
        end
        default: begin
          phase_next         = PH_IDLE;
          result.result_kind = KIND_IGNORED;
        end
      endcase
    end
  end

  // search state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else if (proc) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      left_end   <= left_end_next;
      right_end  <= right_end_next;
      inner_low  <= inner_low_next;
      inner_high <= inner_high_next;
      value_low  <= value_low_next;
      value_high <= value_high_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proceed) begin
      out_valid <= in_q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      out_item <= result;
    end
  end

  `ASSERT_NEXT(a_idle_value_ignored, clk, rst,
               proc && in_q.req_type == REQ_VALUE && phase == PH_IDLE,
               out_valid && out_item.result_kind == KIND_IGNORED)
  `ASSERT_NEXT(a_start_asks_low, clk, rst,
               proc && in_q.req_type == REQ_START,
               phase == PH_FIRST_LOW && out_item.result_kind == KIND_EVAL)
  `ASSERT_IMPLIES(a_interval_ordered, clk, rst,
                  phase != PH_IDLE, left_end <= right_end)
  `ASSERT_IMPLIES(a_done_leaves_idle, clk, rst,
                  out_valid && out_item.result_kind == KIND_DONE, phase == PH_IDLE)

endmodule

`default_nettype wire

// ----- tb/golden_section_minimizer_tb.sv -----
// self-checking testbench for golden_section_minimizer
// predicts every result item from its own model of the search and compares fields
// depends on gsm_pkg and the golden_section_minimizer rtl
`timescale 1ns / 1ps

module golden_section_minimizer_tb;
  import gsm_pkg::*;

  localparam int FRAC_BITS = 24;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PRINT_LIMIT = 100;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_item;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  golden_section_minimizer #(
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // bound and tolerance registers as the block should hold them
  logic signed [31:0] bound_a;
  logic signed [31:0] bound_b;
  logic [30:0]        stop_width;

  // search state
  logic signed [31:0] seg_left;
  logic signed [31:0] seg_right;
  logic signed [31:0] probe_low;
  logic signed [31:0] probe_high;
  logic signed [31:0] f_low;
  logic signed [31:0] f_high;
  phase_t             search_phase;

  out_item_t pending_results[$];
  int        mismatches;
  int        search_items;
  int        cycle_count;
  int        send_idle_pct;
  int        recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [31:0] golden_step(logic [32:0] span);
    logic [63:0] prod;
    prod = {31'd0, span} * {32'd0, RATIO_Q32} + 64'h0000_0000_8000_0000;
    return prod[63:32];
  endfunction

  // both probe values known: finish with the midpoint or shrink by one probe
  function automatic out_item_t shrink_or_finish();
    out_item_t   res;
    logic signed [32:0] l;
    logic signed [32:0] r;
    logic [32:0] span;
    l = seg_left;
    r = seg_right;
    span = r - l;
    if (span <= {2'b00, stop_width} || span <= 33'd1) begin
      res.result_kind = KIND_DONE;
      res.point = seg_left + span[32:1];
      search_phase = PH_IDLE;
    end else if (f_low <= f_high) begin
      seg_right = probe_high;
      probe_high = probe_low;
      f_high = f_low;
      r = seg_right;
      span = r - l;
      probe_low = seg_left + golden_step(span);
      res.result_kind = KIND_EVAL;
      res.point = probe_low;
      search_phase = PH_LOW;
    end else begin
      seg_left = probe_low;
      probe_low = probe_high;
      f_low = f_high;
      l = seg_left;
      span = r - l;
      probe_high = seg_right - golden_step(span);
      res.result_kind = KIND_EVAL;
      res.point = probe_high;
      search_phase = PH_HIGH;
    end
    return res;
  endfunction

  function automatic out_item_t advance_search(in_item_t it);
    out_item_t   res;
    logic signed [32:0] a;
    logic signed [32:0] b;
    logic signed [32:0] t;
    logic [31:0] s;
    res.result_kind = KIND_EVAL;
    res.point = '0;
    if (it.req_type == REQ_START) begin
      a = bound_a;
      b = bound_b;
      if (a > b) begin
        t = a;
        a = b;
        b = t;
      end
      t = b - a;
      s = golden_step(t);
      seg_left = a[31:0];
      seg_right = b[31:0];
      probe_low = a[31:0] + s;
      probe_high = b[31:0] - s;
      f_low = '0;
      f_high = '0;
      search_phase = PH_FIRST_LOW;
      res.point = probe_low;
    end else begin
      case (search_phase)
        PH_FIRST_LOW: begin
          f_low = it.sample_value;
          search_phase = PH_FIRST_HIGH;
          res.point = probe_high;
        end
        PH_FIRST_HIGH, PH_HIGH: begin
          f_high = it.sample_value;
          res = shrink_or_finish();
        end
        PH_LOW: begin
          f_low = it.sample_value;
          res = shrink_or_finish();
        end
        default: begin
          search_phase = PH_IDLE;
          res.result_kind = KIND_IGNORED;
        end
      endcase
    end
    return res;
  endfunction

  function automatic logic signed [31:0] pick_sample();
    case ($urandom_range(15))
      0: return (search_phase == PH_LOW) ? f_high : f_low;
      1: return 32'sh8000_0000;
      2: return 32'sh7fff_ffff;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatches < PRINT_LIMIT)
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic send_item(logic req, logic signed [31:0] val);
    in_item_t  it;
    out_item_t res;
    it.req_type = req;
    it.sample_value = val;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    res = advance_search(it);
    if (res.result_kind != KIND_IGNORED) search_items++;
    pending_results.push_back(res);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      CFG_LOWER: bound_a = data;
      CFG_UPPER: bound_b = data;
      CFG_TOL:   stop_width = data[30:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic finish_search();
    while (search_phase != PH_IDLE) send_item(REQ_VALUE, pick_sample());
  endtask

  task automatic set_idling(int send_pct, int stall_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
  endtask

  task automatic test_idle_values();
    send_item(REQ_VALUE, 32'sh7fff_ffff);
    send_item(REQ_VALUE, 32'sh8000_0000);
  endtask

  // reset interval, tie between the first two probes, then restart mid search
  task automatic test_reset_defaults();
    send_item(REQ_START, 32'sh1234_5678);
    send_item(REQ_VALUE, 32'sd5);
    send_item(REQ_VALUE, 32'sd5);
    send_item(REQ_START, '0);
    send_item(REQ_VALUE, 32'sh8000_0000);
    wait_drained();
  endtask

  task automatic test_full_range_reversed();
    write_reg(CFG_LOWER, 32'h7fff_ffff);
    write_reg(CFG_UPPER, 32'h8000_0000);
    write_reg(CFG_TOL, 32'h7fff_ffff);
    send_item(REQ_START, '0);
    send_item(REQ_VALUE, 32'sh7fff_ffff);
    send_item(REQ_VALUE, 32'sh8000_0000);
    finish_search();
    wait_drained();
  endtask

  task automatic test_degenerate_widths();
    write_reg(CFG_TOL, 32'h0);
    write_reg(CFG_LOWER, 32'h0500_0000);
    write_reg(CFG_UPPER, 32'h0500_0000);
    send_item(REQ_START, '0);
    finish_search();
    wait_drained();
    write_reg(CFG_LOWER, 32'h0);
    write_reg(CFG_UPPER, 32'h1);
    send_item(REQ_START, '0);
    finish_search();
    wait_drained();
  endtask

  task automatic test_zero_tolerance();
    write_reg(CFG_LOWER, 32'hffff_fffd);
    write_reg(CFG_UPPER, 32'd20);
    send_item(REQ_START, '0);
    finish_search();
    wait_drained();
  endtask

  task automatic pick_config();
    logic [31:0] lo;
    logic [31:0] hi;
    case ($urandom_range(7))
      0: begin
        lo = 32'h8000_0000;
        hi = 32'h7fff_ffff;
      end
      1: begin
        lo = $urandom;
        hi = lo + $urandom_range(0, 64);
      end
      default: begin
        lo = $urandom;
        hi = lo + $urandom_range(0, 32'h0400_0000);
      end
    endcase
    if ($urandom_range(3) == 0) write_reg(CFG_LOWER, hi);
    else write_reg(CFG_LOWER, lo);
    write_reg(CFG_UPPER, (lo == hi || $urandom_range(3) != 0) ? hi : lo);
    case ($urandom_range(5))
      0: write_reg(CFG_TOL, 32'h0);
      1: write_reg(CFG_TOL, 32'h7fff_ffff);
      2: write_reg(CFG_TOL, {1'b0, 31'($urandom)});
      default: write_reg(CFG_TOL, $urandom_range(0, 4096));
    endcase
  endtask

  // mostly complete searches with random samples, some restarts and stray values
  task automatic test_random_searches(int target);
    int goal;
    goal = search_items + target;
    while (search_items < goal) begin
      if ($urandom_range(3) == 0) begin
        wait_drained();
        pick_config();
      end
      if ($urandom_range(15) == 0) send_item(REQ_VALUE, $urandom);
      send_item(REQ_START, $urandom);
      while (search_phase != PH_IDLE) begin
        if ($urandom_range(39) == 0) send_item(REQ_START, $urandom);
        else send_item(REQ_VALUE, pick_sample());
      end
    end
  endtask

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected item", out_item.point, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_item.result_kind !== want.result_kind)
          report_mismatch("result_kind", out_item.result_kind, want.result_kind);
        if (out_item.point !== want.point)
          report_mismatch("point", out_item.point, want.point);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_LOWER;
    cfg_data = '0;
    mismatches = 0;
    search_items = 0;
    cycle_count = 0;
    bound_a = 32'sd3 <<< FRAC_BITS;
    bound_b = 32'sd5 <<< FRAC_BITS;
    stop_width = 31'(((64'd1 << FRAC_BITS) + 64'd50000) / 64'd100000);
    seg_left = '0;
    seg_right = '0;
    probe_low = '0;
    probe_high = '0;
    f_low = '0;
    f_high = '0;
    search_phase = PH_IDLE;
    set_idling(13, 76);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_idle_values();
    test_reset_defaults();
    test_full_range_reversed();
    test_degenerate_widths();
    test_zero_tolerance();
    test_random_searches(330);
    set_idling(76, 13);
    test_random_searches(330);
    set_idling(0, 0);
    test_random_searches(340);

    wait_drained();
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results left over", pending_results.size(), 0);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
